// File: sv/lkvc_pkg.sv
// Shared definitions for the LRU key-value cache: opcodes, stream field layout
// and the control word broadcast to the row of entry cells.
// Used by lkvc_cell and lru_key_value_cache; depends on nothing else.
`timescale 1ns / 1ps

package lkvc_pkg;

  // Opcodes carried in the low bits of the input stream data.
  localparam logic [2:0] OP_GET_OR_ADD = 3'd0;
  localparam logic [2:0] OP_PROBE      = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_TRIM       = 3'd3;
  localparam logic [2:0] OP_FLUSH      = 3'd4;

  // Fixed field widths of the stream payloads.
  localparam int OP_BITS    = 3;
  localparam int WORD_BITS  = 64;
  localparam int SMALL_BITS = 5;

  // Input data layout: opcode, key, value from bit 0 up.
  localparam int IN_OP_LSB     = 0;
  localparam int IN_KEY_LSB    = IN_OP_LSB + OP_BITS;
  localparam int IN_VALUE_LSB  = IN_KEY_LSB + WORD_BITS;
  localparam int IN_USED_BITS  = IN_VALUE_LSB + WORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  // Output data layout: hit, value_out, entry_count, evicted_count.
  localparam int OUT_HIT_LSB   = 0;
  localparam int OUT_VALUE_LSB = OUT_HIT_LSB + 1;
  localparam int OUT_COUNT_LSB = OUT_VALUE_LSB + WORD_BITS;
  localparam int OUT_EVICT_LSB = OUT_COUNT_LSB + SMALL_BITS;
  localparam int OUT_USED_BITS = OUT_EVICT_LSB + SMALL_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // What every cell does in the current cycle.
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_LOOK,
    CELL_TOUCH,
    CELL_DROP,
    CELL_EVICT,
    CELL_FLUSH
  } cell_op_t;

  // Control word broadcast along the row of cells.
  typedef struct packed {
    cell_op_t op;
    logic     insert;
  } cell_ctl_t;

endpackage

// File: sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Instantiates a row of lkvc_cell entries; depends on lkvc_pkg.
`timescale 1ns / 1ps

// Each item passes through the transfer into the input register, a lookup
// state in which every cell compares its key and the match is registered, and
// an execute state in which all cells update their ranks at once and the result
// is loaded into the output register. Eviction of any number of least recent
// entries happens at once in the execute state, since the victims are exactly
// the entries whose rank reaches the limit. The next item is taken once the
// execute state has passed its result on; a result that waits in the output
// register holds the block in the execute state of the following item only.
// Capacity must be written through cfg_we and cfg_data only while the block
// is idle; the block itself does not enforce this. Values above ENTRIES act
// as ENTRIES and zero stores nothing. No clearing pass is needed after reset.
module lru_key_value_cache #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // Capacity register write.
  input  logic                               cfg_we,
  input  logic [lkvc_pkg::SMALL_BITS-1:0]    cfg_data,
  // Input items.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: opcode[2:0], key[66:3], value[130:67], zero pad.
  input  logic [lkvc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // Results.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: hit[0], value_out[64:1], entry_count[69:65],
  // evicted_count[74:70], zero pad.
  output logic [lkvc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WB = lkvc_pkg::WORD_BITS;
  localparam int SB = lkvc_pkg::SMALL_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [SB-1:0]         capacity;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [2:0]            op;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  hit_q;
  logic [RW-1:0]         hit_rank_q;
  logic [VALUE_BITS-1:0] hit_value_q;

  logic                  in_xfer;
  logic                  exec_go;
  logic [CW-1:0]         eff_cap;
  logic                  cap_pos;
  logic [CW-1:0]         lim;
  logic [CW-1:0]         kept;
  logic [CW-1:0]         evicted;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         res_evicted;
  logic [lkvc_pkg::OUT_DATA_BITS-1:0] res_word;
  lkvc_pkg::cell_ctl_t   cell_ctl;

  logic [ENTRIES:0]      free_chain;
  logic [ENTRIES:0]      hit_chain;
  logic [RW-1:0]         rank_chain [ENTRIES+1];
  logic [VALUE_BITS-1:0] data_chain [ENTRIES+1];
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    sel_vec;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign exec_go       = (state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= SB'(16);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Effective capacity and the eviction limit of the current opcode.
  always_comb begin
    if (32'(capacity) > ENTRIES) eff_cap = CW'(ENTRIES);
    else eff_cap = CW'(capacity);
    cap_pos = (eff_cap != '0);
    if (op == lkvc_pkg::OP_TRIM) lim = eff_cap;
    else lim = cap_pos ? eff_cap - 1'b1 : '0;
    kept    = (count > lim) ? lim : count;
    evicted = (count > lim) ? count - lim : '0;
  end

  // Sequencer: accept, look up, execute.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_xfer) state_next = S_LOOK;
      S_LOOK:  state_next = S_EXEC;
      S_EXEC:  if (exec_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op    <= s_axis_tdata[lkvc_pkg::IN_OP_LSB +: lkvc_pkg::OP_BITS];
      key_q <= s_axis_tdata[lkvc_pkg::IN_KEY_LSB +: KEY_BITS];
      val_q <= s_axis_tdata[lkvc_pkg::IN_VALUE_LSB +: VALUE_BITS];
    end
  end

  // Lookup result gathered along the row.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      hit_q       <= hit_chain[ENTRIES];
      hit_rank_q  <= rank_chain[ENTRIES];
      hit_value_q <= data_chain[ENTRIES];
    end
  end

  // Command to the cells and the result of the item.
  always_comb begin
    cell_ctl.op     = lkvc_pkg::CELL_IDLE;
    cell_ctl.insert = 1'b0;
    count_next      = count;
    res_hit         = 1'b0;
    res_value       = '0;
    res_evicted     = '0;
    if (state == S_LOOK) cell_ctl.op = lkvc_pkg::CELL_LOOK;
    unique case (op)
      lkvc_pkg::OP_GET_OR_ADD: begin
        res_hit = hit_q;
        if (hit_q) begin
          res_value = hit_value_q;
          if (exec_go) cell_ctl.op = lkvc_pkg::CELL_TOUCH;
        end else begin
          res_value   = val_q;
          res_evicted = evicted;
          count_next  = kept + CW'(cap_pos);
          if (exec_go) begin
            cell_ctl.op     = lkvc_pkg::CELL_EVICT;
            cell_ctl.insert = cap_pos;
          end
        end
      end
      lkvc_pkg::OP_PROBE: begin
        res_hit   = hit_q;
        res_value = hit_q ? hit_value_q : '0;
      end
      lkvc_pkg::OP_REMOVE: begin
        res_hit   = hit_q;
        res_value = hit_q ? hit_value_q : '0;
        if (hit_q) begin
          count_next = count - 1'b1;
          if (exec_go) cell_ctl.op = lkvc_pkg::CELL_DROP;
        end
      end
      lkvc_pkg::OP_TRIM: begin
        res_evicted = evicted;
        count_next  = kept;
        if (exec_go) cell_ctl.op = lkvc_pkg::CELL_EVICT;
      end
      lkvc_pkg::OP_FLUSH: begin
        count_next = '0;
        if (exec_go) cell_ctl.op = lkvc_pkg::CELL_FLUSH;
      end
      default: begin
      end
    endcase
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (exec_go) count <= count_next;
  end

  // Result word packed for the output register.
  always_comb begin
    res_word                                  = '0;
    res_word[lkvc_pkg::OUT_HIT_LSB]           = res_hit;
    res_word[lkvc_pkg::OUT_VALUE_LSB +: WB]   = WB'(res_value);
    res_word[lkvc_pkg::OUT_COUNT_LSB +: SB]   = SB'(count_next);
    res_word[lkvc_pkg::OUT_EVICT_LSB +: SB]   = SB'(res_evicted);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (exec_go) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_axis_tdata <= res_word;
    end
  end

  // Row of entry cells.
  assign free_chain[0] = 1'b0;
  assign hit_chain[0]  = 1'b0;
  assign rank_chain[0] = '0;
  assign data_chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_BITS  (RW),
      .COUNT_BITS (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .key_in   (key_q),
      .value_in (val_q),
      .hit_rank (hit_rank_q),
      .limit    (lim),
      .free_in  (free_chain[i]),
      .free_out (free_chain[i+1]),
      .hit_in   (hit_chain[i]),
      .hit_out  (hit_chain[i+1]),
      .rank_in  (rank_chain[i]),
      .rank_out (rank_chain[i+1]),
      .data_in  (data_chain[i]),
      .data_out (data_chain[i+1]),
      .valid    (valid_vec[i]),
      .sel      (sel_vec[i])
    );
  end

  // The count register tracks the valid cells exactly.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count differs from the number of valid cells");

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= ENTRIES)
    else $error("entry count above the number of cells");

  // A lookup selects at most one cell.
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(sel_vec))
    else $error("more than one cell matched the key");

  // After eviction the count is within the limit, plus one for an insert.
  a_evict_limit: assert property (@(posedge clk) disable iff (rst)
    (cell_ctl.op == lkvc_pkg::CELL_EVICT) |=>
      (32'(count) <= 32'($past(lim)) + 32'($past(cell_ctl.insert))))
    else $error("eviction left too many entries");

endmodule

// File: sv/lkvc_cell.sv
// One entry of the LRU key-value cache: valid bit, key, value and recency rank.
// Cells form a row; lookup results and the free-slot search pass from cell to cell.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_cell #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  parameter int RANK_BITS  = 4,
  parameter int COUNT_BITS = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lkvc_pkg::cell_ctl_t     ctl,
  input  logic [KEY_BITS-1:0]     key_in,
  input  logic [VALUE_BITS-1:0]   value_in,
  input  logic [RANK_BITS-1:0]    hit_rank,
  input  logic [COUNT_BITS-1:0]   limit,
  input  logic                    free_in,
  output logic                    free_out,
  input  logic                    hit_in,
  output logic                    hit_out,
  input  logic [RANK_BITS-1:0]    rank_in,
  output logic [RANK_BITS-1:0]    rank_out,
  input  logic [VALUE_BITS-1:0]   data_in,
  output logic [VALUE_BITS-1:0]   data_out,
  output logic                    valid,
  output logic                    sel
);

  logic [KEY_BITS-1:0]   entry_key;
  logic [VALUE_BITS-1:0] entry_value;
  logic [RANK_BITS-1:0]  rank;
  logic                  match;
  logic                  evict_me;
  logic                  free_here;
  logic                  fill;

  // Key compare and the lookup chain: at most one valid cell matches.
  always_comb begin
    match    = valid && (entry_key == key_in);
    hit_out  = hit_in | match;
    rank_out = rank_in | (match ? rank : '0);
    data_out = data_in | (match ? entry_value : '0);
  end

  // Entries whose rank reaches the limit are the least recent ones to evict.
  // The lowest cell that is free after eviction takes the new pair.
  always_comb begin
    evict_me  = valid && (COUNT_BITS'(rank) >= limit);
    free_here = !valid || evict_me;
    fill      = ctl.insert && free_here && !free_in;
    free_out  = free_in | free_here;
  end

  // Valid bit and the registered match of the last lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
    end else begin
      unique case (ctl.op)
        lkvc_pkg::CELL_LOOK: begin
          sel <= match;
        end
        lkvc_pkg::CELL_DROP: begin
          if (sel) valid <= 1'b0;
        end
        lkvc_pkg::CELL_EVICT: begin
          if (fill) valid <= 1'b1;
          else if (evict_me) valid <= 1'b0;
        end
        lkvc_pkg::CELL_FLUSH: begin
          valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Rank bookkeeping and the stored pair.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      lkvc_pkg::CELL_TOUCH: begin
        if (sel) rank <= '0;
        else if (valid && rank < hit_rank) rank <= rank + 1'b1;
      end
      lkvc_pkg::CELL_DROP: begin
        if (!sel && valid && rank > hit_rank) rank <= rank - 1'b1;
      end
      lkvc_pkg::CELL_EVICT: begin
        if (fill) begin
          rank        <= '0;
          entry_key   <= key_in;
          entry_value <= value_in;
        end else if (valid && !evict_me && ctl.insert) begin
          rank <= rank + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for lru_key_value_cache: directed and random
// get-or-add/probe/remove/trim/flush traffic over several capacities.
// Depends on lkvc_pkg and the RTL of the cache; needs no other files.
`timescale 1ns / 1ps

// One result as it leaves the cache.
typedef struct {
  logic        hit;
  logic [63:0] value;
  logic [4:0]  count;
  logic [4:0]  evicted;
} cache_reply_t;

// Mirror of the cache contents that predicts each reply and checks it.
class lru_cache_mirror;
  localparam int SLOTS = 16;

  bit           valid [SLOTS];
  logic [63:0]  keys [SLOTS];
  logic [63:0]  vals [SLOTS];
  int unsigned  rank [SLOTS];
  int unsigned  count;
  int unsigned  capacity;
  int           errors;
  cache_reply_t pending_replies [$];

  function new();
    foreach (valid[i]) begin
      valid[i] = 1'b0;
      rank[i]  = 0;
    end
    count    = 0;
    capacity = 16;
    errors   = 0;
  endfunction

  function int pending();
    return pending_replies.size();
  endfunction

  task report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("tb_top: mismatch in %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  // Remove one entry and close the gap it leaves in the ranks.
  function void drop(input int slot);
    int unsigned r;
    r = rank[slot];
    valid[slot] = 1'b0;
    foreach (valid[j]) begin
      if (valid[j] && rank[j] > r) rank[j]--;
    end
    if (count > 0) count--;
  endfunction

  // Evict least recent entries until at most limit remain.
  function int unsigned evict_to(input int unsigned limit);
    int unsigned n;
    int victim;
    n = 0;
    while (count > limit) begin
      victim = -1;
      foreach (valid[j]) begin
        if (valid[j] && rank[j] == count - 1) victim = j;
      end
      if (victim < 0) break;
      drop(victim);
      n++;
    end
    return n;
  endfunction

  // Work out the reply to one accepted request and queue it.
  function void note_request(input logic [2:0] op, input logic [63:0] key,
                             input logic [63:0] value);
    cache_reply_t r;
    int slot;
    int free_slot;
    int unsigned eff;
    r.hit     = 1'b0;
    r.value   = '0;
    r.evicted = '0;
    slot      = -1;
    free_slot = -1;
    eff       = (capacity > SLOTS) ? SLOTS : capacity;
    if (op == lkvc_pkg::OP_GET_OR_ADD || op == lkvc_pkg::OP_PROBE ||
        op == lkvc_pkg::OP_REMOVE) begin
      foreach (valid[i]) begin
        if (valid[i] && keys[i] == key && slot < 0) slot = i;
      end
      if (slot >= 0) begin
        r.hit   = 1'b1;
        r.value = vals[slot];
        if (op == lkvc_pkg::OP_GET_OR_ADD) begin
          // A hit moves the entry to the front; everything newer shifts back.
          foreach (valid[j]) begin
            if (valid[j] && rank[j] < rank[slot]) rank[j]++;
          end
          rank[slot] = 0;
        end else if (op == lkvc_pkg::OP_REMOVE) begin
          drop(slot);
        end
      end else if (op == lkvc_pkg::OP_GET_OR_ADD) begin
        // A miss makes room first; with zero capacity nothing is stored.
        r.value   = value;
        r.evicted = 5'(evict_to(eff > 0 ? eff - 1 : 0));
        if (eff > 0) begin
          foreach (valid[j]) begin
            if (!valid[j] && free_slot < 0) free_slot = j;
          end
          if (free_slot >= 0) begin
            foreach (valid[i]) begin
              if (valid[i]) rank[i]++;
            end
            valid[free_slot] = 1'b1;
            keys[free_slot]  = key;
            vals[free_slot]  = value;
            rank[free_slot]  = 0;
            count++;
          end
        end
      end
    end else if (op == lkvc_pkg::OP_TRIM) begin
      r.evicted = 5'(evict_to(eff));
    end else if (op == lkvc_pkg::OP_FLUSH) begin
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        rank[i]  = 0;
      end
      count = 0;
    end
    r.count = 5'(count);
    pending_replies.push_back(r);
  endfunction

  // Compare one result transfer with the oldest prediction.
  task check_reply(input logic [lkvc_pkg::OUT_DATA_BITS-1:0] word);
    cache_reply_t want;
    logic [63:0]  got_value;
    got_value = word[lkvc_pkg::OUT_VALUE_LSB +: 64];
    if (pending_replies.size() == 0) begin
      report("result with nothing pending", got_value, '0);
    end else begin
      want = pending_replies.pop_front();
      if (word[lkvc_pkg::OUT_HIT_LSB] !== want.hit)
        report("hit", 64'(word[lkvc_pkg::OUT_HIT_LSB]), 64'(want.hit));
      if (got_value !== want.value)
        report("value_out", got_value, want.value);
      if (word[lkvc_pkg::OUT_COUNT_LSB +: 5] !== want.count)
        report("entry_count", 64'(word[lkvc_pkg::OUT_COUNT_LSB +: 5]), 64'(want.count));
      if (word[lkvc_pkg::OUT_EVICT_LSB +: 5] !== want.evicted)
        report("evicted_count", 64'(word[lkvc_pkg::OUT_EVICT_LSB +: 5]),
               64'(want.evicted));
    end
  endtask
endclass

module tb_top;
  localparam int          CACHE_ENTRIES = 16;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          PHASES        = 14;
  localparam logic [2:0]  OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  OP_UNUSED_MID = 3'd6;
  localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [lkvc_pkg::SMALL_BITS-1:0]    cfg_data = '0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [lkvc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [lkvc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

  lru_cache_mirror mirror;
  logic [63:0]     key_pool [32];
  bit              no_idle = 1'b0;
  int              cycles = 0;

  lru_key_value_cache #(
    .ENTRIES    (CACHE_ENTRIES),
    .KEY_BITS   (64),
    .VALUE_BITS (64)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Watch both sides: requests feed the mirror, results are checked against it.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      mirror.note_request(s_axis_tdata[lkvc_pkg::IN_OP_LSB +: lkvc_pkg::OP_BITS],
                          s_axis_tdata[lkvc_pkg::IN_KEY_LSB +: 64],
                          s_axis_tdata[lkvc_pkg::IN_VALUE_LSB +: 64]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      mirror.check_reply(m_axis_tdata);
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready for a while, then a random stall.
  initial begin : result_sink
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until the transfer, then maybe idle.
  task automatic send_item(input logic [2:0] op, input logic [63:0] key,
                           input logic [63:0] value);
    logic [lkvc_pkg::IN_DATA_BITS-1:0] word;
    int gap;
    word = '0;
    word[lkvc_pkg::IN_OP_LSB +: lkvc_pkg::OP_BITS] = op;
    word[lkvc_pkg::IN_KEY_LSB +: 64]   = key;
    word[lkvc_pkg::IN_VALUE_LSB +: 64] = value;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has been checked.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity changes only while the cache is idle.
  task automatic write_capacity(input logic [4:0] cap);
    settle();
    cfg_data <= cap;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.capacity = cap;
  endtask

  // One random request: keys mostly from a small pool so hits are common.
  task automatic send_random_item(input int span);
    logic [2:0]  op;
    logic [63:0] key;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 50)      op = lkvc_pkg::OP_GET_OR_ADD;
    else if (r < 68) op = lkvc_pkg::OP_PROBE;
    else if (r < 82) op = lkvc_pkg::OP_REMOVE;
    else if (r < 91) op = lkvc_pkg::OP_TRIM;
    else if (r < 94) op = lkvc_pkg::OP_FLUSH;
    else             op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, span - 1)];
    else key = {$urandom, $urandom};
    send_item(op, key, {$urandom, $urandom});
  endtask

  initial begin : stimulus
    logic [4:0] cap_plan [PHASES];
    int         items;
    int         span;
    mirror = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};
    cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd8,
                 5'd16, 5'd3, 5'd12, 5'd15, 5'd4, 5'd0};
    cap_plan[PHASES - 1] = 5'($urandom_range(0, 31));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small capacity, extreme keys and values, hits and misses.
    write_capacity(5'd4);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[0], '1);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[1], '0);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[0], 64'h1234);
    send_item(lkvc_pkg::OP_PROBE, key_pool[1], '0);
    send_item(lkvc_pkg::OP_PROBE, 64'h5555_5555_5555_5555, '0);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[2], 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[3], 64'h5555_5555_5555_5555);
    // Full cache: this miss pushes out the least recent entry.
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[4], 64'h8000_0000_0000_0001);
    send_item(lkvc_pkg::OP_REMOVE, key_pool[2], '0);
    send_item(lkvc_pkg::OP_REMOVE, key_pool[2], '0);
    send_item(OP_UNUSED_LO, key_pool[0], '1);
    send_item(OP_UNUSED_MID, key_pool[0], '1);
    send_item(OP_UNUSED_HI, key_pool[4], '1);
    // Capacity lowered below the count: entries stay until trimmed.
    write_capacity(5'd1);
    send_item(lkvc_pkg::OP_PROBE, key_pool[0], '0);
    send_item(lkvc_pkg::OP_TRIM, '0, '0);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[5], 64'hDEAD_BEEF_0000_FFFF);
    // Zero capacity stores nothing and empties the cache on a miss.
    write_capacity(5'd0);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[6], '1);
    send_item(lkvc_pkg::OP_PROBE, key_pool[6], '0);
    send_item(lkvc_pkg::OP_TRIM, '1, '1);
    // Capacity above the entry count acts as a full-size cache.
    write_capacity(5'd31);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[7], 64'h0F0F_0F0F_0F0F_0F0F);
    send_item(lkvc_pkg::OP_GET_OR_ADD, key_pool[8], 64'hF0F0_F0F0_F0F0_F0F0);
    send_item(lkvc_pkg::OP_FLUSH, '0, '0);
    send_item(lkvc_pkg::OP_PROBE, key_pool[7], '0);

    // Random phases, one capacity each; some run without random request gaps or result stalls.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_capacity(cap_plan[phase]);
      no_idle = ($urandom_range(0, 3) == 0);
      items   = $urandom_range(90, 118);
      span    = $urandom_range(3, 32);
      for (int n = 0; n < items; n++) begin
        if (phase % 4 == 1 && n == items / 2) settle();
        send_random_item(span);
      end
    end
    no_idle = 1'b0;

    settle();
    if (mirror.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
